// ===== design/esai_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop / alarm interlock package
// Shared widths, codes and payload types for the E-stop and alarm interlock.
// ----------------------------------------------------------------------------
package esai_pkg;

    localparam int CNT_W      = 13;
    localparam int ELAPSED_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0]     CNT_SAT     = 13'd5000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = 8'd255;

    localparam logic [CNT_W-1:0]     LATCH_TICKS_RST   = 13'd5;
    localparam logic [CNT_W-1:0]     CLEAR_TICKS_RST   = 13'd50;
    localparam logic [ELAPSED_W-1:0] CONFIRM_TICKS_RST = 8'd5;

    typedef enum logic [1:0] {
        FAULT_OK      = 2'd0,
        FAULT_PRESSED = 2'd1,
        FAULT_GLITCH  = 2'd2,
        FAULT_ALARM   = 2'd3
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LATCH_TICKS   = 2'd0,
        CFG_CLEAR_TICKS   = 2'd1,
        CFG_CONFIRM_TICKS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]     alarm_latch_ticks;
        logic [CNT_W-1:0]     alarm_clear_ticks;
        logic [ELAPSED_W-1:0] estop_confirm_ticks;
    } t_cfg;

    typedef struct packed {
        logic estop_pressed;
        logic estop_edge;
        logic alarm_active;
        logic reset_request;
        logic controller_in_estop;
    } t_tick;

    typedef struct packed {
        logic   disable_drive;
        logic   force_stop;
        logic   enter_estop;
        logic   locked;
        logic   alarm_latched;
        t_fault fault_code;
        logic   inhibit_motion;
        logic   reset_accepted;
        logic   reset_refused;
    } t_result;

endpackage

// ===== design/esai_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop / alarm interlock channels
// Valid/ready channels for tick requests, results and register writes.
// ----------------------------------------------------------------------------
interface esai_tick_if;
    logic valid;
    logic ready;
    logic estop_pressed;
    logic estop_edge;
    logic alarm_active;
    logic reset_request;
    logic controller_in_estop;

    modport source (
        output valid, estop_pressed, estop_edge, alarm_active, reset_request,
               controller_in_estop,
        input  ready
    );
    modport sink (
        input  valid, estop_pressed, estop_edge, alarm_active, reset_request,
               controller_in_estop,
        output ready
    );
endinterface

interface esai_result_if;
    logic       valid;
    logic       ready;
    logic       disable_drive;
    logic       force_stop;
    logic       enter_estop;
    logic       locked;
    logic       alarm_latched;
    logic [1:0] fault_code;
    logic       inhibit_motion;
    logic       reset_accepted;
    logic       reset_refused;

    modport source (
        output valid, disable_drive, force_stop, enter_estop, locked, alarm_latched,
               fault_code, inhibit_motion, reset_accepted, reset_refused,
        input  ready
    );
    modport sink (
        input  valid, disable_drive, force_stop, enter_estop, locked, alarm_latched,
               fault_code, inhibit_motion, reset_accepted, reset_refused,
        output ready
    );
endinterface

interface esai_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [esai_pkg::CFG_IDX_W-1:0]  index;
    logic [esai_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/estop_alarm_safety_interlock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop and driver-alarm safety interlock
// Debounces the driver alarm, confirms E-stop edges and guards lock resets.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick   - one request per 1 ms tick with the sampled E-stop and alarm
//              levels, the E-stop edge flag, a reset request and the
//              controller's E-stop state.
//   o_result - one result per tick: drive/stop/E-stop pulses, lock, alarm
//              latch, fault code, motion inhibit and reset outcome.
//   i_cfg    - register writes (latch ticks, clear ticks, confirm ticks);
//              always ready, write only while no tick is in flight.
// A request is registered on acceptance and evaluated by the core; its result
// is loaded into the output register once the result slot is free or draining,
// and o_result.valid then stays high until the receiver takes the result.
// Throughput: one tick per cycle while the receiver takes results; the state
// update is a single pass of counter compares and flag logic between the input
// and result registers. Reset clears the interlock state, both pipeline valids
// and loads the register defaults (5, 50, 5). When the receiver stalls the
// result is held and one more request is still taken into the input register.
// ----------------------------------------------------------------------------
module estop_alarm_safety_interlock (
    input  logic           i_clk,
    input  logic           i_rst_n,
    esai_tick_if.sink      i_tick,
    esai_result_if.source  o_result,
    esai_cfg_if.sink       i_cfg
);

    esai_pkg::t_cfg    w_cfg;
    esai_pkg::t_result w_result;

    logic              r_in_valid;
    esai_pkg::t_tick   r_in;
    logic              r_out_valid;
    esai_pkg::t_result r_out;
    logic              w_advance;
    logic              w_accept;

    esai_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    esai_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_tick   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // advance when a request is held and the result slot is free or draining
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_advance;
    assign w_accept     = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.estop_pressed       <= i_tick.estop_pressed;
            r_in.estop_edge          <= i_tick.estop_edge;
            r_in.alarm_active        <= i_tick.alarm_active;
            r_in.reset_request       <= i_tick.reset_request;
            r_in.controller_in_estop <= i_tick.controller_in_estop;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.disable_drive  = r_out.disable_drive;
    assign o_result.force_stop     = r_out.force_stop;
    assign o_result.enter_estop    = r_out.enter_estop;
    assign o_result.locked         = r_out.locked;
    assign o_result.alarm_latched  = r_out.alarm_latched;
    assign o_result.fault_code     = r_out.fault_code;
    assign o_result.inhibit_motion = r_out.inhibit_motion;
    assign o_result.reset_accepted = r_out.reset_accepted;
    assign o_result.reset_refused  = r_out.reset_refused;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_reset_outcome_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.reset_accepted && r_out.reset_refused))
        else $error("reset both accepted and refused");

    a_accepted_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reset_accepted) |->
            (!r_out.locked && !r_out.alarm_latched &&
             r_out.fault_code == esai_pkg::FAULT_OK))
        else $error("accepted reset left lock, latch or fault set");

    a_latch_inhibits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alarm_latched) |-> r_out.inhibit_motion)
        else $error("alarm latched without motion inhibit");

    a_stall_holds_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held request lost while stalled");
`endif

endmodule

// ===== design/esai_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop / alarm interlock register file
// Decodes register writes into the three threshold registers.
// ----------------------------------------------------------------------------
module esai_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    esai_cfg_if.sink           i_cfg,
    output esai_pkg::t_cfg     o_cfg
);

    esai_pkg::t_cfg r_cfg;
    esai_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (esai_pkg::t_cfg_idx'(i_cfg.index))
                esai_pkg::CFG_LATCH_TICKS: begin
                    n_cfg.alarm_latch_ticks = i_cfg.data;
                end
                esai_pkg::CFG_CLEAR_TICKS: begin
                    n_cfg.alarm_clear_ticks = i_cfg.data;
                end
                esai_pkg::CFG_CONFIRM_TICKS: begin
                    n_cfg.estop_confirm_ticks = i_cfg.data[esai_pkg::ELAPSED_W-1:0];
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_latch_ticks   <= esai_pkg::LATCH_TICKS_RST;
            r_cfg.alarm_clear_ticks   <= esai_pkg::CLEAR_TICKS_RST;
            r_cfg.estop_confirm_ticks <= esai_pkg::CONFIRM_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/esai_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop / alarm interlock core
// Holds the interlock state and computes one tick's update and result.
// ----------------------------------------------------------------------------
module esai_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  esai_pkg::t_tick     i_tick,
    input  esai_pkg::t_cfg      i_cfg,
    output esai_pkg::t_result   o_result
);

    logic [esai_pkg::CNT_W-1:0]     r_low_cnt,  n_low_cnt;
    logic [esai_pkg::CNT_W-1:0]     r_high_cnt, n_high_cnt;
    logic                           r_latch,    n_latch;
    logic                           r_lock,     n_lock;
    logic                           r_pending,  n_pending;
    logic                           r_running,  n_running;
    logic [esai_pkg::ELAPSED_W-1:0] r_elapsed,  n_elapsed;
    esai_pkg::t_fault               r_fault,    n_fault;

    always_comb begin
        logic in_estop;
        logic dis;
        logic stop;
        logic enter;
        logic acc;
        logic refused;

        n_low_cnt  = r_low_cnt;
        n_high_cnt = r_high_cnt;
        n_latch    = r_latch;
        n_lock     = r_lock;
        n_pending  = r_pending;
        n_running  = r_running;
        n_elapsed  = r_elapsed;
        n_fault    = r_fault;
        in_estop   = i_tick.controller_in_estop;
        dis        = 1'b0;
        stop       = 1'b0;
        enter      = 1'b0;
        acc        = 1'b0;
        refused    = 1'b0;

        if (i_tick.estop_edge) begin
            dis       = 1'b1;
            n_pending = 1'b1;
        end

        // alarm debounce: two saturating run counters
        if (i_tick.alarm_active) begin
            n_high_cnt = '0;
            if (r_low_cnt < esai_pkg::CNT_SAT) begin
                n_low_cnt = r_low_cnt + 1'b1;
            end
            if (n_low_cnt >= i_cfg.alarm_latch_ticks && !r_latch) begin
                n_latch = 1'b1;
                n_fault = esai_pkg::FAULT_ALARM;
                dis     = 1'b1;
                stop    = 1'b1;
                if (!in_estop) begin
                    enter    = 1'b1;
                    in_estop = 1'b1;
                    n_lock   = 1'b1;
                end
            end
        end else begin
            n_low_cnt = '0;
            if (r_high_cnt < esai_pkg::CNT_SAT) begin
                n_high_cnt = r_high_cnt + 1'b1;
            end
            if (n_high_cnt >= i_cfg.alarm_clear_ticks) begin
                n_latch = 1'b0;
            end
        end

        if (i_tick.reset_request) begin
            if (!i_tick.estop_pressed && !n_latch) begin
                n_lock    = 1'b0;
                n_pending = 1'b0;
                n_running = 1'b0;
                n_elapsed = '0;
                n_fault   = esai_pkg::FAULT_OK;
                acc       = 1'b1;
            end else begin
                refused = 1'b1;
            end
        end

        // confirm timer: first tick stops the stepper, then check the level
        if (n_pending) begin
            if (!n_running) begin
                n_running = 1'b1;
                n_elapsed = '0;
                stop      = 1'b1;
            end else if (n_elapsed < esai_pkg::ELAPSED_SAT) begin
                n_elapsed = n_elapsed + 1'b1;
            end
            if (n_elapsed >= i_cfg.estop_confirm_ticks) begin
                if (i_tick.estop_pressed) begin
                    n_fault = esai_pkg::FAULT_PRESSED;
                    if (!in_estop) begin
                        enter    = 1'b1;
                        in_estop = 1'b1;
                        n_lock   = 1'b1;
                    end
                end else begin
                    n_fault = esai_pkg::FAULT_GLITCH;
                    if (!in_estop) begin
                        enter    = 1'b1;
                        in_estop = 1'b1;
                    end
                    n_lock = 1'b1;
                end
                n_pending = 1'b0;
                n_running = 1'b0;
                n_elapsed = '0;
            end
        end

        o_result.disable_drive  = dis;
        o_result.force_stop     = stop;
        o_result.enter_estop    = enter;
        o_result.locked         = n_lock;
        o_result.alarm_latched  = n_latch;
        o_result.fault_code     = n_fault;
        o_result.inhibit_motion = i_tick.estop_pressed | n_latch;
        o_result.reset_accepted = acc;
        o_result.reset_refused  = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
            r_latch    <= 1'b0;
            r_lock     <= 1'b0;
            r_pending  <= 1'b0;
            r_running  <= 1'b0;
            r_elapsed  <= '0;
            r_fault    <= esai_pkg::FAULT_OK;
        end else if (i_step) begin
            r_low_cnt  <= n_low_cnt;
            r_high_cnt <= n_high_cnt;
            r_latch    <= n_latch;
            r_lock     <= n_lock;
            r_pending  <= n_pending;
            r_running  <= n_running;
            r_elapsed  <= n_elapsed;
            r_fault    <= n_fault;
        end
    end

endmodule

// ===== test/estop_alarm_safety_interlock_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E-stop / alarm interlock testbench
// Drives tick requests and register writes into the interlock, predicts every
// tick result from its own copy of the debounce, confirm and lock state, and
// compares each returned result field by field in order. Both channels stall
// at random; one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
import esai_pkg::*;

class interlock_scoreboard;
    t_result               expected_q[$];
    int unsigned           errors;
    int unsigned           checked;

    logic [CNT_W-1:0]      latch_ticks;
    logic [CNT_W-1:0]      clear_ticks;
    logic [ELAPSED_W-1:0]  confirm_ticks;

    logic [CNT_W-1:0]      active_run;
    logic [CNT_W-1:0]      quiet_run;
    logic                  alarm_held;
    logic                  lock_held;
    logic                  confirm_armed;
    logic                  timer_running;
    logic [ELAPSED_W-1:0]  timer_ticks;
    t_fault                fault;

    function new();
        errors        = 0;
        checked       = 0;
        latch_ticks   = LATCH_TICKS_RST;
        clear_ticks   = CLEAR_TICKS_RST;
        confirm_ticks = CONFIRM_TICKS_RST;
        active_run    = '0;
        quiet_run     = '0;
        alarm_held    = 1'b0;
        lock_held     = 1'b0;
        confirm_armed = 1'b0;
        timer_running = 1'b0;
        timer_ticks   = '0;
        fault         = FAULT_OK;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_LATCH_TICKS:   latch_ticks   = value;
            CFG_CLEAR_TICKS:   clear_ticks   = value;
            CFG_CONFIRM_TICKS: confirm_ticks = value[ELAPSED_W-1:0];
            default: ;
        endcase
    endfunction

    // Work out the result of one accepted tick and queue it.
    function void note_tick(t_tick t);
        t_result r;
        logic    in_estop;
        r        = '0;
        in_estop = t.controller_in_estop;

        if (t.estop_edge) begin
            r.disable_drive = 1'b1;
            confirm_armed   = 1'b1;
        end

        if (t.alarm_active) begin
            quiet_run = '0;
            if (active_run < CNT_SAT) active_run++;
            if (active_run >= latch_ticks && !alarm_held) begin
                alarm_held      = 1'b1;
                fault           = FAULT_ALARM;
                r.disable_drive = 1'b1;
                r.force_stop    = 1'b1;
                if (!in_estop) begin
                    r.enter_estop = 1'b1;
                    in_estop      = 1'b1;
                    lock_held     = 1'b1;
                end
            end
        end else begin
            active_run = '0;
            if (quiet_run < CNT_SAT) quiet_run++;
            if (quiet_run >= clear_ticks) alarm_held = 1'b0;
        end

        if (t.reset_request) begin
            if (!t.estop_pressed && !alarm_held) begin
                lock_held        = 1'b0;
                confirm_armed    = 1'b0;
                timer_running    = 1'b0;
                timer_ticks      = '0;
                fault            = FAULT_OK;
                r.reset_accepted = 1'b1;
            end else begin
                r.reset_refused = 1'b1;
            end
        end

        if (confirm_armed) begin
            if (!timer_running) begin
                timer_running = 1'b1;
                timer_ticks   = '0;
                r.force_stop  = 1'b1;
            end else if (timer_ticks < ELAPSED_SAT) begin
                timer_ticks++;
            end
            if (timer_ticks >= confirm_ticks) begin
                if (t.estop_pressed) begin
                    fault = FAULT_PRESSED;
                    if (!in_estop) begin
                        r.enter_estop = 1'b1;
                        lock_held     = 1'b1;
                    end
                end else begin
                    // a glitch locks even when the controller is already stopped
                    fault = FAULT_GLITCH;
                    if (!in_estop) r.enter_estop = 1'b1;
                    lock_held = 1'b1;
                end
                confirm_armed = 1'b0;
                timer_running = 1'b0;
                timer_ticks   = '0;
            end
        end

        r.locked         = lock_held;
        r.alarm_latched  = alarm_held;
        r.fault_code     = fault;
        r.inhibit_motion = t.estop_pressed | alarm_held;
        expected_q.push_back(r);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task field_check(string name, logic [1:0] got_v, logic [1:0] want_v);
        if (got_v !== want_v)
            report($sformatf("result %0d %s: got %0d, expected %0d",
                             checked, name, got_v, want_v));
    endtask

    task check_result(t_result got);
        t_result want;
        if (expected_q.size() == 0) begin
            report($sformatf("result %h arrived with no tick outstanding", got));
            return;
        end
        want = expected_q.pop_front();
        field_check("disable_drive",  got.disable_drive,  want.disable_drive);
        field_check("force_stop",     got.force_stop,     want.force_stop);
        field_check("enter_estop",    got.enter_estop,    want.enter_estop);
        field_check("locked",         got.locked,         want.locked);
        field_check("alarm_latched",  got.alarm_latched,  want.alarm_latched);
        field_check("fault_code",     got.fault_code,     want.fault_code);
        field_check("inhibit_motion", got.inhibit_motion, want.inhibit_motion);
        field_check("reset_accepted", got.reset_accepted, want.reset_accepted);
        field_check("reset_refused",  got.reset_refused,  want.reset_refused);
        checked++;
    endtask
endclass

module estop_alarm_safety_interlock_test;

    localparam int unsigned            CYCLE_LIMIT = 300000;
    localparam int unsigned            LONG_HOLD   = 80;
    localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED  = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned ticks_sent = 0;
    int unsigned cycle_count = 0;

    interlock_scoreboard sb = new();

    esai_tick_if   tick_ch ();
    esai_result_if result_ch ();
    esai_cfg_if    cfg_ch ();

    estop_alarm_safety_interlock dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("estop_alarm_safety_interlock verification failed");
            $finish;
        end
    end

    function automatic bit one_in(int unsigned n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic t_tick mk_tick(bit pressed, bit edge_seen, bit alarm, bit rst_req,
                                      bit ctl_estop);
        t_tick t;
        t.estop_pressed       = pressed;
        t.estop_edge          = edge_seen;
        t.alarm_active        = alarm;
        t.reset_request       = rst_req;
        t.controller_in_estop = ctl_estop;
        return t;
    endfunction

    // Offer one tick request, possibly after an idle burst; valid stays high after.
    task automatic send_tick(t_tick t);
        if (!no_idle && one_in(5)) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        tick_ch.valid               <= 1'b1;
        tick_ch.estop_pressed       <= t.estop_pressed;
        tick_ch.estop_edge          <= t.estop_edge;
        tick_ch.alarm_active        <= t.alarm_active;
        tick_ch.reset_request       <= t.reset_request;
        tick_ch.controller_in_estop <= t.controller_in_estop;
        do @(posedge i_clk); while (!tick_ch.ready);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    // Stop offering and wait until every outstanding result is back.
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] latch_v, logic [CFG_DATA_W-1:0] clear_v,
                                logic [CFG_DATA_W-1:0] confirm_v, bit poke_unused);
        logic [CFG_IDX_W-1:0]  idxs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        int                    n;
        idxs[0] = CFG_LATCH_TICKS;   vals[0] = latch_v;
        idxs[1] = CFG_CLEAR_TICKS;   vals[1] = clear_v;
        idxs[2] = CFG_CONFIRM_TICKS; vals[2] = confirm_v;
        idxs[3] = CFG_UNUSED;        vals[3] = 13'h1555;
        n = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[i];
            cfg_ch.data  <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            sb.set_reg(idxs[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int unsigned count);
        int unsigned target;
        int unsigned len;
        bit          ctl;
        target = ticks_sent + count;
        while (ticks_sent < target) begin
            ctl = one_in(4);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // hold the button through the confirm window, then release and clear
                    len = sb.confirm_ticks + $urandom_range(0, 3);
                    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, ctl));
                    repeat (len)
                        send_tick(mk_tick(1'b1, one_in(16), one_in(8), one_in(8), ctl));
                    repeat ($urandom_range(1, 3))
                        send_tick(mk_tick(1'b0, 1'b0, 1'b0, one_in(2), ctl));
                    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
                end
                3, 4: begin
                    // edge with the button mostly released by the level check
                    len = sb.confirm_ticks + $urandom_range(0, 3);
                    send_tick(mk_tick(one_in(4), 1'b1, 1'b0, 1'b0, ctl));
                    repeat (len)
                        send_tick(mk_tick(one_in(6), one_in(20), 1'b0, one_in(10), ctl));
                    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, ctl));
                end
                5, 6: begin
                    // alarm run around the latch threshold, then a quiet run to clear it
                    len = (sb.latch_ticks > 40) ? $urandom_range(1, 40)
                                                : sb.latch_ticks + $urandom_range(0, 2);
                    if (len == 0) len = 1;
                    repeat (len)
                        send_tick(mk_tick(one_in(10), one_in(20), !one_in(12), one_in(10), ctl));
                    len = (sb.clear_ticks > 60) ? $urandom_range(1, 60)
                                                : sb.clear_ticks + $urandom_range(0, 2);
                    if (len == 0) len = 1;
                    repeat (len)
                        send_tick(mk_tick(one_in(10), 1'b0, one_in(15), one_in(8), ctl));
                    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, ctl));
                end
                7: begin
                    repeat ($urandom_range(1, 4))
                        send_tick(mk_tick(one_in(2), 1'b0, one_in(4), 1'b1, one_in(2)));
                end
                default: begin
                    repeat ($urandom_range(1, 10))
                        send_tick(t_tick'(5'($urandom_range(0, 31))));
                end
            endcase
            if (one_in(80)) drain_results();
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        got.disable_drive  = result_ch.disable_drive;
        got.force_stop     = result_ch.force_stop;
        got.enter_estop    = result_ch.enter_estop;
        got.locked         = result_ch.locked;
        got.alarm_latched  = result_ch.alarm_latched;
        got.fault_code     = t_fault'(result_ch.fault_code);
        got.inhibit_motion = result_ch.inhibit_motion;
        got.reset_accepted = result_ch.reset_accepted;
        got.reset_refused  = result_ch.reset_refused;
        if (i_rst_n && result_ch.valid && result_ch.ready) sb.check_result(got);
    end

    initial begin : result_sink
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold-off: let the block fill up and stall its input
                hold_req        <= 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else if (!no_idle && one_in(6)) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n                     <= 1'b0;
        tick_ch.valid               <= 1'b0;
        tick_ch.estop_pressed       <= 1'b0;
        tick_ch.estop_edge          <= 1'b0;
        tick_ch.alarm_active        <= 1'b0;
        tick_ch.reset_request       <= 1'b0;
        tick_ch.controller_in_estop <= 1'b0;
        cfg_ch.valid                <= 1'b0;
        cfg_ch.index                <= CFG_LATCH_TICKS;
        cfg_ch.data                 <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at the reset register values
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (5) send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        repeat (5) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        repeat (5) send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));

        hold_req <= 1'b1;
        run_random(150);

        drain_results();
        write_config(13'd1, 13'd1, 13'd0, 1'b0);
        run_random(150);

        // zero thresholds act as one; confirm takes only its low byte
        drain_results();
        write_config(13'd0, 13'd0, 13'h1FFF, 1'b0);
        run_random(150);

        drain_results();
        write_config(13'h1FFF, 13'h1FFF, 13'd1, 1'b1);
        run_random(100);

        drain_results();
        write_config(13'd2, 13'd5000, 13'd3, 1'b0);
        run_random(100);

        repeat (3) begin
            drain_results();
            write_config(13'($urandom_range(1, 12)), 13'($urandom_range(1, 40)),
                         13'($urandom_range(0, 12)), 1'b0);
            run_random(100);
        end

        drain_results();
        no_idle <= 1'b1;
        write_config(LATCH_TICKS_RST, CLEAR_TICKS_RST, 13'(CONFIRM_TICKS_RST), 1'b0);
        run_random(100);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("estop_alarm_safety_interlock verification clean");
        end else begin
            $display("estop_alarm_safety_interlock verification failed");
        end
        $finish;
    end

endmodule
